// ===== hdl/rth_pkg.sv =====
package rth_pkg;

   localparam int CH_W    = 8;   // one color channel
   localparam int SAT_W   = 8;   // saturation divisor and remainder (max channel)
   localparam int HUE_W   = 11;  // hue divisor and remainder (six times max-min)
   localparam int OUT_W   = 16;  // hue and saturation result fields
   localparam int REQ_W   = 3 * CH_W;
   localparam int RSP_W   = 2 * OUT_W + CH_W;

   typedef struct packed {
      logic valid;
      logic sat_zero;   // black pixel
      logic sat_top;    // min channel is zero
      logic hue_zero;   // grey pixel
   } ctl_type;

   typedef struct packed {
      logic [CH_W-1:0]  bright;
      logic [SAT_W-1:0] sat_div;
      logic [SAT_W-1:0] sat_rem;
      logic [HUE_W-1:0] hue_div;
      logic [HUE_W-1:0] hue_rem;
   } lane_type;

endpackage

// ===== hdl/rgb_to_hsb_core.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tdata: red[7:0] green[15:8] blue[23:16]
// rsp_      out        rsp_tvalid/tready     tdata: hue[15:0] sat[31:16] bright[39:32]
//
// One pixel enters per cycle while req_tready is high; its result passes through
// the input register, one division cell per fraction bit, and the
// output register. Both divisions (hue and saturation) run side by side in
// the same row of cells. Reset is synchronous and clears all valid flags.
// A stalled result is held in a two-entry output buffer; req_tready drops
// only once that buffer is full, and then the whole row of cells holds.
module rgb_to_hsb_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rth_pkg::REQ_W-1:0]   req_tdata,   // red_in, green_in, blue_in
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rth_pkg::RSP_W-1:0]   rsp_tdata    // hue_out, saturation_out, brightness_out
);

   localparam int OW = rth_pkg::OUT_W;

   rth_pkg::ctl_type     ctl_c   [0:FRAC_BITS];
   rth_pkg::lane_type    lane_c  [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] sat_q_c [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] hue_q_c [0:FRAC_BITS];
   logic                 advance;
   logic [FRAC_BITS-1:0] sat_full;
   logic [FRAC_BITS-1:0] hue_full;
   logic [OW-1:0]        hue_val;
   logic [OW-1:0]        sat_val;
   logic [rth_pkg::RSP_W-1:0] push_data;
   logic                 push_valid;

   rth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .ctl_o    (ctl_c[0]),
      .lane_o   (lane_c[0])
   );

   assign sat_q_c[0] = '0;
   assign hue_q_c[0] = '0;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
      rth_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (ctl_c[k]),
         .lane_i  (lane_c[k]),
         .sat_q_i (sat_q_c[k]),
         .hue_q_i (hue_q_c[k]),
         .ctl_o   (ctl_c[k+1]),
         .lane_o  (lane_c[k+1]),
         .sat_q_o (sat_q_c[k+1]),
         .hue_q_o (hue_q_c[k+1])
      );
   end

   // apply black, grey and full-saturation overrides at the end of the row
   always_comb begin
      if (ctl_c[FRAC_BITS].sat_zero) begin
         sat_full = '0;
      end else if (ctl_c[FRAC_BITS].sat_top) begin
         sat_full = '1;
      end else begin
         sat_full = sat_q_c[FRAC_BITS];
      end
      hue_full  = ctl_c[FRAC_BITS].hue_zero ? '0 : hue_q_c[FRAC_BITS];
      hue_val   = OW'(hue_full);
      sat_val   = OW'(sat_full);
      push_data = {lane_c[FRAC_BITS].bright, sat_val, hue_val};
   end

   assign push_valid = ctl_c[FRAC_BITS].valid && advance;
   assign req_tready = advance;

   rth_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata)
   );

endmodule

// ===== hdl/rth_front.sv =====
module rth_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [rth_pkg::REQ_W-1:0]      in_data,
   output rth_pkg::ctl_type               ctl_o,
   output rth_pkg::lane_type              lane_o
);

   localparam int CW = rth_pkg::CH_W;
   localparam int HW = rth_pkg::HUE_W;

   logic [CW-1:0]     red;
   logic [CW-1:0]     green;
   logic [CW-1:0]     blue;
   logic [CW-1:0]     mx;
   logic [CW-1:0]     mn;
   logic [CW-1:0]     diff;
   logic [HW-1:0]     d_w;
   logic [HW-1:0]     six_d;
   logic [HW-1:0]     num;
   rth_pkg::ctl_type  ctl_in;
   rth_pkg::ctl_type  ctl_ff;
   rth_pkg::lane_type lane_in;
   rth_pkg::lane_type lane_ff;

   assign red   = in_data[CW-1:0];
   assign green = in_data[2*CW-1:CW];
   assign blue  = in_data[3*CW-1:2*CW];

   always_comb begin
      mx = (red > green) ? red : green;
      mn = (red < green) ? red : green;
      if (blue > mx) begin
         mx = blue;
      end
      if (blue < mn) begin
         mn = blue;
      end
      diff  = mx - mn;
      d_w   = HW'(diff);
      six_d = (d_w << 2) + (d_w << 1);
      // numerator stays in [0, 6d); intermediate wrap in HW bits is harmless
      priority if (red == mx) begin
         if (green >= blue) begin
            num = HW'(green) - HW'(blue);
         end else begin
            num = six_d - (HW'(blue) - HW'(green));
         end
      end else if (green == mx) begin
         num = (d_w << 1) + HW'(blue) - HW'(red);
      end else begin
         num = (d_w << 2) + HW'(red) - HW'(green);
      end

      ctl_in.valid    = in_valid;
      ctl_in.sat_zero = (mx == '0);
      ctl_in.sat_top  = (mn == '0);
      ctl_in.hue_zero = (diff == '0);

      lane_in.bright  = mx;
      lane_in.sat_div = mx;
      lane_in.sat_rem = (mn == '0) ? '0 : diff;
      lane_in.hue_div = six_d;
      lane_in.hue_rem = num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign lane_o = lane_ff;

endmodule

// ===== hdl/rth_cell.sv =====
module rth_cell #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rth_pkg::ctl_type      ctl_i,
   input  rth_pkg::lane_type     lane_i,
   input  logic [FRAC_BITS-1:0]  sat_q_i,
   input  logic [FRAC_BITS-1:0]  hue_q_i,
   output rth_pkg::ctl_type      ctl_o,
   output rth_pkg::lane_type     lane_o,
   output logic [FRAC_BITS-1:0]  sat_q_o,
   output logic [FRAC_BITS-1:0]  hue_q_o
);

   localparam int SW = rth_pkg::SAT_W;
   localparam int HW = rth_pkg::HUE_W;

   logic [SW:0]          sat_two;
   logic [SW:0]          sat_sub;
   logic                 sat_bit;
   logic [HW:0]          hue_two;
   logic [HW:0]          hue_sub;
   logic                 hue_bit;
   rth_pkg::ctl_type     ctl_ff;
   rth_pkg::lane_type    lane_in;
   rth_pkg::lane_type    lane_ff;
   logic [FRAC_BITS-1:0] sat_q_in;
   logic [FRAC_BITS-1:0] sat_q_ff;
   logic [FRAC_BITS-1:0] hue_q_in;
   logic [FRAC_BITS-1:0] hue_q_ff;

   // one restoring division step per lane: double, compare, subtract
   always_comb begin
      sat_two = {lane_i.sat_rem, 1'b0};
      sat_sub = sat_two - {1'b0, lane_i.sat_div};
      sat_bit = (sat_two >= {1'b0, lane_i.sat_div});
      hue_two = {lane_i.hue_rem, 1'b0};
      hue_sub = hue_two - {1'b0, lane_i.hue_div};
      hue_bit = (hue_two >= {1'b0, lane_i.hue_div});

      lane_in         = lane_i;
      lane_in.sat_rem = sat_bit ? sat_sub[SW-1:0] : sat_two[SW-1:0];
      lane_in.hue_rem = hue_bit ? hue_sub[HW-1:0] : hue_two[HW-1:0];
      sat_q_in        = {sat_q_i[FRAC_BITS-2:0], sat_bit};
      hue_q_in        = {hue_q_i[FRAC_BITS-2:0], hue_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff  <= lane_in;
         sat_q_ff <= sat_q_in;
         hue_q_ff <= hue_q_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign lane_o  = lane_ff;
   assign sat_q_o = sat_q_ff;
   assign hue_q_o = hue_q_ff;

endmodule

// ===== hdl/rth_skid.sv =====
module rth_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  logic [rth_pkg::RSP_W-1:0]   push_data,
   output logic                        push_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rth_pkg::RSP_W-1:0]   out_data
);

   logic                      out_valid_ff;
   logic [rth_pkg::RSP_W-1:0] out_data_ff;
   logic                      spare_valid_ff;
   logic [rth_pkg::RSP_W-1:0] spare_data_ff;
   logic                      pop;

   assign pop = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (spare_valid_ff) begin
         // no push while the spare is full; drain it on a pop
         if (pop) begin
            out_valid_ff   <= 1'b1;
            spare_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push_valid;
      end else if (push_valid) begin
         spare_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (spare_valid_ff) begin
         if (pop) begin
            out_data_ff <= spare_data_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_data_ff <= push_data;
      end else begin
         spare_data_ff <= push_data;
      end
   end

   assign push_ready = !spare_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule

// ===== hdl/rth_checker.sv =====
module rth_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [rth_pkg::RSP_W-1:0]  rsp_tdata
);

   // a held request must not vanish
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // input stalls only when a finished request is waiting at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no pending request at the output");

   // black pixel gives zero hue and zero saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[39:32] == 8'd0) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("nonzero hue or saturation for a black pixel");

   // reset leaves no request at the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind rgb_to_hsb_core rth_checker u_rth_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int FRAC = 16;
   localparam int SETTLE_CYCLES = FRAC + 12;
   localparam int RANDOM_PER_PHASE = 342;

   typedef struct packed {
      logic [rth_pkg::CH_W-1:0]  bright;
      logic [rth_pkg::OUT_W-1:0] sat;
      logic [rth_pkg::OUT_W-1:0] hue;
   } hsb_type;

   class hsb_scoreboard;
      hsb_type pending_q[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // Exact hexcone conversion at FRAC fraction bits.
      function hsb_type convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [63:0] rr, gg, bb, mx, mn, d, num, sat, hue, top;
         hsb_type res;
         rr = {56'b0, r};
         gg = {56'b0, g};
         bb = {56'b0, b};
         mx = (rr > gg) ? rr : gg;
         mn = (rr < gg) ? rr : gg;
         if (bb > mx) mx = bb;
         if (bb < mn) mn = bb;
         d = mx - mn;
         top = (64'd1 << FRAC) - 64'd1;
         sat = 64'd0;
         hue = 64'd0;
         if (mx != 64'd0) begin
            sat = (d << FRAC) / mx;
            if (sat > top) sat = top;
         end
         if (d != 64'd0) begin
            // red wins ties over green, green over blue
            if (rr == mx) begin
               num = (gg >= bb) ? (gg - bb) : (64'd6 * d - (bb - gg));
            end else if (gg == mx) begin
               num = 64'd2 * d + bb - rr;
            end else begin
               num = 64'd4 * d + rr - gg;
            end
            hue = (num << FRAC) / (64'd6 * d);
         end
         res.hue    = hue[rth_pkg::OUT_W-1:0];
         res.sat    = sat[rth_pkg::OUT_W-1:0];
         res.bright = mx[rth_pkg::CH_W-1:0];
         return res;
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         pending_q.push_back(convert_pixel(r, g, b));
      endfunction

      function void check_result(hsb_type got);
         hsb_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.hue !== want.hue) begin
            $display("%0t: hue expected %h actual %h", $time, want.hue, got.hue);
            errors++;
         end
         if (got.sat !== want.sat) begin
            $display("%0t: saturation expected %h actual %h", $time, want.sat, got.sat);
            errors++;
         end
         if (got.bright !== want.bright) begin
            $display("%0t: brightness expected %h actual %h", $time, want.bright,
                     got.bright);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [rth_pkg::REQ_W-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [rth_pkg::RSP_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   hsb_scoreboard board = new();

   rgb_to_hsb_core #(
      .FRAC_BITS (FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Leaves req_tvalid high after acceptance so back-to-back requests need no toggle.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      board.note_pixel(r, g, b);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [7:0] r, g, b, v;
      int mode;
      for (int i = 0; i < count; i++) begin
         r = 8'($urandom_range(255));
         g = 8'($urandom_range(255));
         b = 8'($urandom_range(255));
         v = 8'($urandom_range(255));
         mode = $urandom_range(9);
         case (mode)
            0: begin
               r = v; g = v; b = v;
            end
            1: begin
               if ($urandom_range(1)) r = g; else g = b;
            end
            2: begin
               r = r & 8'h03; g = g & 8'h03; b = b & 8'h03;
            end
            3: begin
               case ($urandom_range(2))
                  0: r = 8'd0;
                  1: g = 8'd0;
                  default: b = 8'd0;
               endcase
            end
            4: begin
               case ($urandom_range(2))
                  0: r = 8'hff;
                  1: g = 8'hff;
                  default: b = 8'hff;
               endcase
            end
            default: begin
            end
         endcase
         send_pixel(r, g, b);
      end
   endtask

   always begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clock);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 76;
      // black, white, grey, primaries and secondaries (ties)
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      // red largest with blue above green wraps below zero
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd1,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd1);
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd50,  8'd200, 8'd100);
      send_pixel(8'd100, 8'd50,  8'd200);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd1,   8'd1);
      send_pixel(8'd170, 8'd85,  8'd170);
      send_pixel(8'd2,   8'd1,   8'd3);
      send_random(RANDOM_PER_PHASE);

      // hold off until the pipeline is empty
      drain_results();
      send_idle_pct = 76;
      recv_idle_pct = 10;
      send_random(RANDOM_PER_PHASE);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(RANDOM_PER_PHASE);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
